### hdl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

### hdl/caldays_pkg.sv
// types, constants and calendar tables for the date to epoch converter
`default_nettype none

package caldays_pkg;

   localparam int unsigned MAX_YEAR_OFFSET = 127;
   // 2100 is the only non-leap multiple of four in range (offset from 2000)
   localparam int unsigned CENTURY_OFFSET  = 100;
   localparam int unsigned DAYS_PER_YEAR   = 365;
   localparam int unsigned SECS_PER_MIN    = 60;
   localparam int unsigned SECS_PER_HOUR   = 3600;
   localparam int unsigned SECS_PER_DAY    = 86400;
   localparam int unsigned SECS_PER_YEAR   = DAYS_PER_YEAR * SECS_PER_DAY;
   localparam int unsigned LAST_SEC        = 59;
   localparam int unsigned LAST_MIN        = 59;
   localparam int unsigned LAST_HOUR       = 23;
   localparam int unsigned LAST_MONTH      = 12;
   // 2000-01-01 was a saturday, monday is zero
   localparam int unsigned BASE_WEEKDAY    = 5;
   localparam int unsigned DAYS_PER_WEEK   = 7;

   typedef struct packed {
      logic [5:0] second;
      logic [5:0] minute;
      logic [4:0] hour;
      logic [4:0] day;
      logic [3:0] month;
      logic [6:0] year_offset;
   } date_type;

   typedef struct packed {
      logic        valid_res;
      logic [15:0] day_number;
      logic [31:0] epoch_seconds;
      logic [2:0]  weekday;
   } result_type;

   // days in a month, zero for month codes that mean nothing
   function automatic logic [4:0] month_length(input logic leap, input logic [3:0] month);
      logic [4:0] len;
      case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                       len = leap ? 5'd29 : 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

   // days in the year before the first of the month
   function automatic logic [8:0] days_before_month(input logic leap,
                                                    input logic [3:0] month);
      logic [8:0] base;
      case (month)
         4'd2:    base = 9'd31;
         4'd3:    base = 9'd59;
         4'd4:    base = 9'd90;
         4'd5:    base = 9'd120;
         4'd6:    base = 9'd151;
         4'd7:    base = 9'd181;
         4'd8:    base = 9'd212;
         4'd9:    base = 9'd243;
         4'd10:   base = 9'd273;
         4'd11:   base = 9'd304;
         4'd12:   base = 9'd334;
         default: base = 9'd0;
      endcase
      if (leap && (month > 4'd2)) begin
         base = base + 9'd1;
      end
      return base;
   endfunction

   // remainder by seven of a 10-bit value, folding octal digits since 8 = 1 mod 7
   function automatic logic [2:0] mod7(input logic [9:0] v);
      logic [4:0] s1;
      logic [3:0] s2;
      s1 = 5'(v[2:0]) + 5'(v[5:3]) + 5'(v[8:6]) + 5'(v[9]);
      s2 = 4'(s1[2:0]) + 4'(s1[4:3]);
      if (s2 >= 4'(DAYS_PER_WEEK)) begin
         s2 = s2 - 4'(DAYS_PER_WEEK);
      end
      return s2[2:0];
   endfunction

endpackage

`default_nettype wire

### hdl/caldays_conv.sv
// combinational date check and conversion to day count, seconds and weekday
`default_nettype none

module caldays_conv (
   input  caldays_pkg::date_type   date,
   output caldays_pkg::result_type result
);
   import caldays_pkg::*;

   logic        leap;
   logic [5:0]  leap_days;
   logic [7:0]  yo_round;
   logic        fields_ok;
   logic        day_ok;
   logic        ok;
   logic [8:0]  day_in_span;
   logic [15:0] year_days;
   logic [31:0] year_secs;
   logic [31:0] span_secs;
   logic [16:0] tod_secs;
   logic [9:0]  wd_sum;

   // leap year rule, only 2100 is a skipped century in range
   assign leap = (date.year_offset[1:0] == 2'd0)
              && (date.year_offset != 7'(CENTURY_OFFSET));

   // leap days in the years 2000 up to the year before this one
   assign yo_round  = 8'(date.year_offset) + 8'd3;
   assign leap_days = 6'(yo_round[7:2])
                    - 6'(date.year_offset > 7'(CENTURY_OFFSET));

   // field range checks
   assign fields_ok = (date.second <= 6'(LAST_SEC))
                   && (date.minute <= 6'(LAST_MIN))
                   && (date.hour <= 5'(LAST_HOUR))
                   && (date.month != 4'd0)
                   && (date.month <= 4'(LAST_MONTH))
                   && (32'(date.year_offset) <= MAX_YEAR_OFFSET);
   assign day_ok = (date.day != 5'd0) && (date.day <= month_length(leap, date.month));
   assign ok     = fields_ok && day_ok;

   // days past the start of the year, plus leap days of earlier years
   assign day_in_span = 9'(leap_days) + days_before_month(leap, date.month)
                      + 9'(date.day) - 9'd1;

   // independent constant products, summed once
   assign year_days = 16'(date.year_offset) * 16'(DAYS_PER_YEAR);
   assign year_secs = 32'(date.year_offset) * 32'(SECS_PER_YEAR);
   assign span_secs = 32'(day_in_span) * 32'(SECS_PER_DAY);
   assign tod_secs  = 17'(date.hour) * 17'(SECS_PER_HOUR)
                    + 17'(date.minute) * 17'(SECS_PER_MIN)
                    + 17'(date.second);

   // 365 = 1 mod 7, so each year moves the weekday by one
   assign wd_sum = 10'(date.year_offset) + 10'(day_in_span) + 10'(BASE_WEEKDAY);

   // zero all result fields on an invalid date
   always_comb begin
      result = '0;
      if (ok) begin
         result.valid_res     = 1'b1;
         result.day_number    = year_days + 16'(day_in_span);
         result.epoch_seconds = year_secs + span_secs + 32'(tod_secs);
         result.weekday       = mod7(wd_sum);
      end
   end

endmodule

`default_nettype wire

### hdl/calendar_to_day_count_and_seconds.sv
// Calendar date and time to days and seconds since 2000-01-01, with weekday.
// Throughput: one transfer per cycle while rsp_ready stays high; input register,
// one conversion pass, result register, with the input stage able to hold one item
// while a result waits.
// Reset: synchronous, active high; clears the valid flags of both stages.
`default_nettype none

`include "assert_macros.svh"

module calendar_to_day_count_and_seconds (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [5:0]  req_second,
   input  wire logic [5:0]  req_minute,
   input  wire logic [4:0]  req_hour,
   input  wire logic [4:0]  req_day,
   input  wire logic [3:0]  req_month,
   input  wire logic [6:0]  req_year_offset,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic        rsp_valid_res,
   output      logic [15:0] rsp_day_number,
   output      logic [31:0] rsp_epoch_seconds,
   output      logic [2:0]  rsp_weekday
);
   import caldays_pkg::*;

   logic       in_valid_ff;
   logic       in_valid_in;
   date_type   date_ff;
   logic       out_valid_ff;
   logic       out_valid_in;
   result_type result_ff;
   result_type result_in;
   logic       out_free;
   logic       req_xfer;

   // handshake: the output register frees when empty or being taken
   assign out_free  = !out_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || out_free;
   assign req_xfer  = req_valid && req_ready;

   assign in_valid_in  = req_ready ? req_valid : in_valid_ff;
   assign out_valid_in = out_free ? in_valid_ff : out_valid_ff;

   // conversion pass between the two registers
   caldays_conv u_conv (
      .date   (date_ff),
      .result (result_in)
   );

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // input payload register
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         date_ff.second      <= req_second;
         date_ff.minute      <= req_minute;
         date_ff.hour        <= req_hour;
         date_ff.day         <= req_day;
         date_ff.month       <= req_month;
         date_ff.year_offset <= req_year_offset;
      end
   end

   // result payload register
   always_ff @(posedge clock) begin
      if (out_free && in_valid_ff) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_valid_res     = result_ff.valid_res;
   assign rsp_day_number    = result_ff.day_number;
   assign rsp_epoch_seconds = result_ff.epoch_seconds;
   assign rsp_weekday       = result_ff.weekday;

   `ASSERT_SAME(a_invalid_zero, clock, reset,
      out_valid_ff && !result_ff.valid_res,
      result_ff.day_number == 16'd0 && result_ff.epoch_seconds == 32'd0
         && result_ff.weekday == 3'd0,
      "invalid result carries nonzero fields")
   `ASSERT_SAME(a_weekday_range, clock, reset, out_valid_ff && result_ff.valid_res,
      result_ff.weekday < 3'(DAYS_PER_WEEK), "weekday out of range")
   `ASSERT_SAME(a_ready_when_empty, clock, reset, !out_valid_ff, req_ready,
      "request stalled with empty output")
   `ASSERT_NEXT(a_stage_advance, clock, reset, in_valid_ff && out_free, out_valid_ff,
      "converted item not loaded into output")

endmodule

`default_nettype wire

### verif/calendar_to_day_count_and_seconds_tb.sv
// testbench for the calendar date to day count and seconds converter
`timescale 1ns / 1ps

module calendar_to_day_count_and_seconds_tb;
   import caldays_pkg::*;

   localparam int unsigned RANDOM_DATES = 1500;
   localparam int unsigned STALL_LIMIT  = 2000;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned IDLE_PCT     = 6;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [5:0]  req_second = '0;
   logic [5:0]  req_minute = '0;
   logic [4:0]  req_hour = '0;
   logic [4:0]  req_day = '0;
   logic [3:0]  req_month = '0;
   logic [6:0]  req_year_offset = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_valid_res;
   logic [15:0] rsp_day_number;
   logic [31:0] rsp_epoch_seconds;
   logic [2:0]  rsp_weekday;

   // no idling on either side while set
   bit          quiet = 1'b0;
   int unsigned stall_cycles = 0;

   calendar_to_day_count_and_seconds i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_second        (req_second),
      .req_minute        (req_minute),
      .req_hour          (req_hour),
      .req_day           (req_day),
      .req_month         (req_month),
      .req_year_offset   (req_year_offset),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_valid_res     (rsp_valid_res),
      .rsp_day_number    (rsp_day_number),
      .rsp_epoch_seconds (rsp_epoch_seconds),
      .rsp_weekday       (rsp_weekday)
   );

   // gregorian leap rule on the full year
   function automatic bit leap_year(int unsigned year);
      return (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
   endfunction

   function automatic int unsigned days_in_month(bit leap, int unsigned month);
      int unsigned len;
      case (month)
         1, 3, 5, 7, 8, 10, 12: len = 31;
         4, 6, 9, 11:           len = 30;
         2:                     len = leap ? 29 : 28;
         default:               len = 0;
      endcase
      return len;
   endfunction

   class epoch_scoreboard;
      result_type  expected_q[$];
      int unsigned errors = 0;

      // expected conversion of one date
      function result_type convert_date(date_type d);
         result_type  r;
         int unsigned year, days;
         bit          leap;
         r    = '0;
         year = 2000 + d.year_offset;
         leap = leap_year(year);
         if (d.second > LAST_SEC || d.minute > LAST_MIN || d.hour > LAST_HOUR)
            return r;
         if (d.month < 1 || d.month > LAST_MONTH || d.year_offset > MAX_YEAR_OFFSET)
            return r;
         if (d.day < 1 || d.day > days_in_month(leap, d.month))
            return r;
         days = 0;
         for (int unsigned y = 2000; y < year; y++) begin
            days += leap_year(y) ? 366 : 365;
         end
         for (int unsigned m = 1; m < d.month; m++) begin
            days += days_in_month(leap, m);
         end
         days += d.day - 1;
         r.valid_res     = 1'b1;
         r.day_number    = days[15:0];
         r.epoch_seconds = days * SECS_PER_DAY + d.hour * SECS_PER_HOUR
                           + d.minute * SECS_PER_MIN + d.second;
         r.weekday       = 3'((days + BASE_WEEKDAY) % DAYS_PER_WEEK);
         return r;
      endfunction

      function void note_date(date_type d);
         expected_q.push_back(convert_date(d));
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (expected_q.size() == 0) begin
            $error("result transfer with no date pending");
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (got.valid_res !== want.valid_res) begin
            $error("valid_res: expected %0d, got %0d", want.valid_res, got.valid_res);
            errors++;
         end
         if (got.day_number !== want.day_number) begin
            $error("day_number: expected %0d, got %0d", want.day_number, got.day_number);
            errors++;
         end
         if (got.epoch_seconds !== want.epoch_seconds) begin
            $error("epoch_seconds: expected %0d, got %0d",
                   want.epoch_seconds, got.epoch_seconds);
            errors++;
         end
         if (got.weekday !== want.weekday) begin
            $error("weekday: expected %0d, got %0d", want.weekday, got.weekday);
            errors++;
         end
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction
   endclass

   epoch_scoreboard sb = new;

   // clock
   initial begin
      forever #1 clock = ~clock;
   end

   // receiver stalls
   always @(posedge clock) begin
      rsp_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
   end

   // transfer monitor, result check and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            sb.note_date({req_second, req_minute, req_hour, req_day, req_month,
                          req_year_offset});
         end
         if (rsp_valid && rsp_ready) begin
            sb.check_result({rsp_valid_res, rsp_day_number, rsp_epoch_seconds,
                             rsp_weekday});
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
         if (stall_cycles >= STALL_LIMIT) begin
            $display("calendar_to_day_count_and_seconds regression: fail");
            $finish;
         end
      end
   end

   function automatic date_type make_date(int unsigned s, int unsigned mi, int unsigned h,
                                          int unsigned d, int unsigned mo, int unsigned y);
      date_type t;
      t.second      = 6'(s);
      t.minute      = 6'(mi);
      t.hour        = 5'(h);
      t.day         = 5'(d);
      t.month       = 4'(mo);
      t.year_offset = 7'(y);
      return t;
   endfunction

   // mostly well-formed dates, some with one field broken, some pure noise
   function automatic date_type random_date();
      date_type    t;
      int unsigned pick, yo, mo, len;
      pick = $urandom_range(99);
      if (pick >= 85) begin
         return date_type'($urandom);
      end
      yo  = $urandom_range(MAX_YEAR_OFFSET);
      mo  = $urandom_range(1, LAST_MONTH);
      len = days_in_month(leap_year(2000 + yo), mo);
      t = make_date($urandom_range(LAST_SEC), $urandom_range(LAST_MIN),
                    $urandom_range(LAST_HOUR), $urandom_range(1, len), mo, yo);
      // favor the month edges
      if ($urandom_range(3) == 0) begin
         t.day = ($urandom_range(1) == 0) ? 5'd1 : 5'(len);
      end
      if (pick >= 75) begin
         case ($urandom_range(4))
            0: t.day    = (len < 31) ? 5'(len + 1) : 5'd0;
            1: t.second = 6'($urandom_range(LAST_SEC + 1, 63));
            2: t.minute = 6'($urandom_range(LAST_MIN + 1, 63));
            3: t.hour   = 5'($urandom_range(LAST_HOUR + 1, 31));
            default: t.month = ($urandom_range(1) == 0) ? 4'd0
                                  : 4'($urandom_range(LAST_MONTH + 1, 15));
         endcase
      end
      return t;
   endfunction

   // one request transfer, with an occasional gap ahead of it
   task automatic send_date(date_type d);
      if (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_second      <= d.second;
      req_minute      <= d.minute;
      req_hour        <= d.hour;
      req_day         <= d.day;
      req_month       <= d.month;
      req_year_offset <= d.year_offset;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // let the monitor note the last transfer before counting what is pending
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // stimulus
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed corners
      send_date(make_date(0, 0, 0, 1, 1, 0));        // epoch origin
      send_date(make_date(59, 59, 23, 31, 12, 127)); // last valid instant
      send_date(make_date(63, 63, 31, 31, 15, 127)); // every bit set
      send_date(make_date(0, 0, 0, 0, 0, 0));        // every bit clear
      send_date(make_date(0, 0, 0, 29, 2, 0));       // leap day of a 400 year
      send_date(make_date(0, 0, 0, 29, 2, 100));     // century year, no leap day
      send_date(make_date(0, 0, 0, 28, 2, 100));
      send_date(make_date(0, 0, 0, 1, 3, 100));
      send_date(make_date(0, 0, 0, 1, 1, 101));      // first year after the century
      send_date(make_date(0, 0, 0, 29, 2, 4));
      send_date(make_date(0, 0, 0, 29, 2, 1));       // leap day of a common year
      send_date(make_date(60, 0, 0, 1, 1, 0));
      send_date(make_date(0, 60, 0, 1, 1, 0));
      send_date(make_date(0, 0, 24, 1, 1, 0));
      send_date(make_date(0, 0, 0, 1, 13, 0));
      send_date(make_date(0, 0, 0, 31, 4, 10));      // day past a 30 day month
      send_date(make_date(0, 0, 0, 30, 4, 10));
      send_date(make_date(0, 0, 0, 31, 1, 50));
      send_date(make_date(59, 59, 23, 31, 12, 99));
      send_date(make_date(0, 0, 0, 31, 12, 0));
      send_date(make_date(1, 1, 1, 1, 3, 96));
      wait_drained();

      // random dates, with a stretch of full rate and one drain midway
      for (int unsigned n = 0; n < RANDOM_DATES; n++) begin
         quiet = (n >= 500) && (n < 800);
         if (n == 1000) begin
            wait_drained();
         end
         send_date(random_date());
      end
      quiet = 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.errors == 0) begin
         $display("calendar_to_day_count_and_seconds regression: pass");
      end else begin
         $display("calendar_to_day_count_and_seconds regression: fail");
      end
      $finish;
   end

endmodule
